// ----- sv/bat_pkg.sv -----
// Package for the block-average thumbnail generator.
// Holds shared constants, register indexes and controller/datapath structs.
// No dependencies.
`default_nettype none
package bat_pkg;
  localparam int DEF_MAX_WIDTH = 4096;
  localparam int DEF_MAX_SCALE = 16;
  localparam int ROW_LIMIT     = 4096;
  localparam int PIX_W         = 16;
  localparam int DIM_REG_W     = 13;
  localparam int SCALE_REG_W   = 5;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;

  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BIN_SCALE  = 2'd2;

  localparam logic [DIM_REG_W-1:0]   RST_SRC_WIDTH  = 13'd1024;
  localparam logic [DIM_REG_W-1:0]   RST_SRC_HEIGHT = 13'd1024;
  localparam logic [SCALE_REG_W-1:0] RST_BIN_SCALE  = 5'd4;

  typedef struct packed {
    logic accept;
    logic update;
    logic div_step;
    logic load_out;
  } bat_cmd_t;

  typedef struct packed {
    logic produce;
    logic div_done;
    logic out_free;
  } bat_sts_t;
endpackage
`default_nettype wire

// ----- sv/bat_ctrl.sv -----
// Controller state machine for the block-average thumbnail generator.
// Sequences accept, column-sum update, division and result delivery; uses bat_pkg.
`default_nettype none
module bat_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  input  bat_pkg::bat_sts_t sts,
  output bat_pkg::bat_cmd_t cmd
);
  import bat_pkg::*;

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_UPDATE  = 2'd1;
  localparam logic [1:0] S_DIVIDE  = 2'd2;
  localparam logic [1:0] S_DELIVER = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = sts.produce ? S_DIVIDE : S_IDLE;
      end
      S_DIVIDE: begin
        if (sts.div_done) state_next = S_DELIVER;
        else cmd.div_step = 1'b1;
      end
      S_DELIVER: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule
`default_nettype wire

// ----- sv/bat_datapath.sv -----
// Datapath for the block-average thumbnail generator: position counters,
// column-sum memory, block accumulator, serial divider and output register. Uses bat_pkg.
`default_nettype none
module bat_datapath #(
  parameter int MAX_WIDTH = bat_pkg::DEF_MAX_WIDTH,
  parameter int MAX_SCALE = bat_pkg::DEF_MAX_SCALE
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 restart,
  input  wire [bat_pkg::DIM_REG_W-1:0]        width_reg,
  input  wire [bat_pkg::DIM_REG_W-1:0]        height_reg,
  input  wire [bat_pkg::SCALE_REG_W-1:0]      scale_reg,
  input  bat_pkg::bat_cmd_t                   cmd,
  output bat_pkg::bat_sts_t                   sts,
  input  wire signed [bat_pkg::PIX_W-1:0]     pixel_value,
  output logic signed [bat_pkg::PIX_W-1:0]    average_value,
  output logic                                last_of_image,
  output logic                                out_valid,
  input  wire                                 out_stall
);
  import bat_pkg::*;

  localparam int LS   = $clog2(MAX_SCALE);
  localparam int SW   = $clog2(MAX_SCALE + 1);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = CW + 1;
  localparam int RW   = $clog2(ROW_LIMIT);
  localparam int HW   = RW + 1;
  localparam int EXW  = ((WW > SW) ? WW : SW) + 2;
  localparam int EXH  = ((HW > SW) ? HW : SW) + 2;
  localparam int CSW  = PIX_W + LS;
  localparam int SUMW = PIX_W + 2 * LS;
  localparam int DW   = 2 * SW;
  localparam int NW   = $clog2(SUMW + 1);

  // Clamped geometry.
  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [SW-1:0] s;

  always_comb begin
    if (width_reg == '0) w = WW'(1);
    else if (32'(width_reg) > 32'(MAX_WIDTH)) w = WW'(MAX_WIDTH);
    else w = WW'(width_reg);
    if (height_reg == '0) h = HW'(1);
    else if (32'(height_reg) > 32'(ROW_LIMIT)) h = HW'(ROW_LIMIT);
    else h = HW'(height_reg);
    if (scale_reg == '0) s = SW'(1);
    else if (32'(scale_reg) > 32'(MAX_SCALE)) s = SW'(MAX_SCALE);
    else s = SW'(scale_reg);
  end

  // Position within the image and within the current square.
  logic [CW-1:0] col;
  logic [SW-1:0] cb;
  logic [RW-1:0] row;
  logic [SW-1:0] rb;

  logic [EXW-1:0] col_base;
  logic [EXH-1:0] row_base;
  logic           col_end, row_end;
  logic           in_col, in_row, col_last_sq, row_last_sq;
  logic           cb_last, rb_last;

  always_comb begin
    col_base    = EXW'(col) - EXW'(cb);
    row_base    = EXH'(row) - EXH'(rb);
    col_end     = (EXW'(col) + EXW'(1)) == EXW'(w);
    row_end     = (EXH'(row) + EXH'(1)) == EXH'(h);
    in_col      = (col_base + EXW'(s)) <= EXW'(w);
    in_row      = (row_base + EXH'(s)) <= EXH'(h);
    col_last_sq = (col_base + EXW'(s) + EXW'(s)) > EXW'(w);
    row_last_sq = (row_base + EXH'(s) + EXH'(s)) > EXH'(h);
    cb_last     = (cb == s - SW'(1));
    rb_last     = (rb == s - SW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      cb  <= '0;
      row <= '0;
      rb  <= '0;
    end else if (cmd.accept) begin
      if (col_end) begin
        col <= '0;
        cb  <= '0;
        if (row_end) begin
          row <= '0;
          rb  <= '0;
        end else begin
          row <= row + RW'(1);
          rb  <= rb_last ? '0 : rb + SW'(1);
        end
      end else begin
        col <= col + CW'(1);
        cb  <= cb_last ? '0 : cb + SW'(1);
      end
    end
  end

  // Transaction context captured at accept.
  logic signed [PIX_W-1:0] pix;
  logic [CW-1:0]           col_q;
  logic                    insq_q, rb0_q, rbl_q, cb0_q, cbl_q, last_q;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix    <= pixel_value;
      col_q  <= col;
      insq_q <= in_col && in_row;
      rb0_q  <= (rb == '0);
      rbl_q  <= rb_last;
      cb0_q  <= (cb == '0);
      cbl_q  <= cb_last;
      last_q <= rb_last && cb_last && row_last_sq && col_last_sq;
    end
  end

  // Column-sum memory with registered read.
  logic signed [CSW-1:0] col_mem [MAX_WIDTH];
  logic signed [CSW-1:0] rdata;
  logic signed [CSW-1:0] col_new;

  assign col_new = rb0_q ? CSW'(pix) : rdata + CSW'(pix);

  always_ff @(posedge clk) begin
    if (cmd.accept) rdata <= col_mem[col];
    if (cmd.update && insq_q) col_mem[col_q] <= col_new;
  end

  // Horizontal running sum over the band's last row.
  logic signed [SUMW-1:0] run_sum;
  logic signed [SUMW-1:0] run_new;

  assign run_new = cb0_q ? SUMW'(col_new) : run_sum + SUMW'(col_new);
  assign sts.produce = insq_q && rbl_q && cbl_q;

  always_ff @(posedge clk) begin
    if (rst || restart) run_sum <= '0;
    else if (cmd.update && insq_q && rbl_q) run_sum <= run_new;
  end

  // Restoring divider on the magnitude, one quotient bit per cycle.
  logic [SUMW-1:0] quo;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   divisor;
  logic [NW-1:0]   dcnt;
  logic            neg;
  logic [DW:0]     trial;

  assign trial        = {rem, quo[SUMW-1]} - {1'b0, divisor};
  assign sts.div_done = (dcnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.update && sts.produce) begin
      dcnt <= NW'(SUMW);
    end else if (cmd.div_step) begin
      dcnt <= dcnt - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && sts.produce) begin
      neg     <= run_new[SUMW-1];
      quo     <= run_new[SUMW-1] ? SUMW'(-run_new) : SUMW'(run_new);
      rem     <= '0;
      divisor <= DW'(s) * DW'(s);
    end else if (cmd.div_step) begin
      if (!trial[DW]) begin
        rem <= trial[DW-1:0];
        quo <= {quo[SUMW-2:0], 1'b1};
      end else begin
        rem <= {rem[DW-2:0], quo[SUMW-1]};
        quo <= {quo[SUMW-2:0], 1'b0};
      end
    end
  end

  // Output register.
  logic [PIX_W-1:0] q16;
  assign q16          = quo[PIX_W-1:0];
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      average_value <= neg ? -q16 : q16;
      last_of_image <= last_q;
    end
  end
endmodule
`default_nettype wire

// ----- sv/block_average_thumbnail.sv -----
// Block-average thumbnail generator top level: APB registers, controller, datapath.
// Depends on bat_pkg, bat_ctrl and bat_datapath.
// A pixel that completes no square passes through accept and column-sum update; one that
// completes a square is also divided by the bit-serial divider and then waits for a free
// output register, with the result valid at the end. One pixel is in flight at a time.
// Synchronous active-high reset restores register defaults and restarts the image;
// the column-sum memory is not cleared (each entry is written before it is read).
`default_nettype none
module block_average_thumbnail #(
  parameter int MAX_WIDTH = bat_pkg::DEF_MAX_WIDTH,
  parameter int MAX_SCALE = bat_pkg::DEF_MAX_SCALE
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire [bat_pkg::ADDR_W-1:0]         paddr,
  input  wire [bat_pkg::DATA_W-1:0]         pwdata,
  output logic [bat_pkg::DATA_W-1:0]        prdata,
  output logic                              pready,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire signed [bat_pkg::PIX_W-1:0]   pixel_value,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic signed [bat_pkg::PIX_W-1:0]  average_value,
  output logic                              last_of_image
);
  import bat_pkg::*;

  logic [DIM_REG_W-1:0]   source_width;
  logic [DIM_REG_W-1:0]   source_height;
  logic [SCALE_REG_W-1:0] bin_scale;
  logic                   cfg_write;
  logic [1:0]             reg_idx;
  bat_cmd_t               cmd;
  bat_sts_t               sts;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= RST_SRC_WIDTH;
      source_height <= RST_SRC_HEIGHT;
      bin_scale     <= RST_BIN_SCALE;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_SRC_WIDTH:  source_width  <= pwdata[DIM_REG_W-1:0];
        REG_SRC_HEIGHT: source_height <= pwdata[DIM_REG_W-1:0];
        REG_BIN_SCALE:  bin_scale     <= pwdata[SCALE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SRC_WIDTH:  prdata = DATA_W'(source_width);
      REG_SRC_HEIGHT: prdata = DATA_W'(source_height);
      REG_BIN_SCALE:  prdata = DATA_W'(bin_scale);
      default:        prdata = '0;
    endcase
  end

  bat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bat_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .restart       (cfg_write),
    .width_reg     (source_width),
    .height_reg    (source_height),
    .scale_reg     (bin_scale),
    .cmd           (cmd),
    .sts           (sts),
    .pixel_value   (pixel_value),
    .average_value (average_value),
    .last_of_image (last_of_image),
    .out_valid     (out_valid),
    .out_stall     (out_stall)
  );

  // A result is only loaded when the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending transaction");

  // After an accepted transaction the block is busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted on consecutive cycles");

  // The divider runs only between an update and the delivery of its result.
  a_div_only_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (in_stall && !sts.div_done))
    else $error("divider stepped outside a division");
endmodule
`default_nettype wire
